FILE: rtl/lco_pkg.sv
// Shared constants, codes and state types of the line clipper.
package lco_pkg;

  localparam int LCO_COORD_WIDTH = 16;
  localparam int LCO_MAX_CLIPS   = 4;
  localparam int LCO_STEP_W      = $clog2(LCO_MAX_CLIPS + 1);
  localparam int LCO_CFG_IDX_W   = 2;

  // outcode bits
  localparam logic [3:0] OC_LEFT   = 4'b0001;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_BOTTOM = 4'b0100;
  localparam logic [3:0] OC_TOP    = 4'b1000;

  // configuration register indexes
  localparam logic [LCO_CFG_IDX_W-1:0] CFG_RECT_X0 = 2'd0;
  localparam logic [LCO_CFG_IDX_W-1:0] CFG_RECT_Y0 = 2'd1;
  localparam logic [LCO_CFG_IDX_W-1:0] CFG_RECT_X1 = 2'd2;
  localparam logic [LCO_CFG_IDX_W-1:0] CFG_RECT_Y1 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WAIT,
    ST_UPDATE,
    ST_OUT
  } lco_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } lco_md_state_t;

endpackage

FILE: rtl/lco_if.sv
// Segment request and clip result stream interfaces.
interface lco_seg_if import lco_pkg::*; #(
  parameter int W = LCO_COORD_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x,
                input end_y, output ready);
endinterface

interface lco_clip_if import lco_pkg::*; #(
  parameter int W = LCO_COORD_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic                accepted;
  logic signed [W-1:0] clip_start_x;
  logic signed [W-1:0] clip_start_y;
  logic signed [W-1:0] clip_end_x;
  logic signed [W-1:0] clip_end_y;

  modport source (output valid, output accepted, output clip_start_x,
                  output clip_start_y, output clip_end_x, output clip_end_y,
                  input ready);
  modport sink (input valid, input accepted, input clip_start_x,
                input clip_start_y, input clip_end_x, input clip_end_y,
                output ready);
endinterface

FILE: rtl/line_clip_outcode.sv
// Top level of the Cohen-Sutherland line clipper.
// Clips one segment per request against the rectangle spanned by the two
// configured corners. Each clip step runs one multiply and a serial divide
// on the shared unit in lco_muldiv, one quotient bit per cycle. Requests are
// taken only when the sequencer is idle; a finished result waits in its own
// output register so the next request can be taken meanwhile. Rejected
// segments return accepted low and zero coordinates. The user must write the
// corners through the cfg_ port only while no request is in flight; the
// block itself does not enforce this.
module line_clip_outcode import lco_pkg::*; #(
  parameter int COORD_WIDTH = LCO_COORD_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [LCO_CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]   cfg_data,
  lco_seg_if.sink                  in_seg,
  lco_clip_if.source               out_clip
);

  localparam int W = COORD_WIDTH;

  function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y,
                                         input logic signed [W-1:0] l,
                                         input logic signed [W-1:0] r,
                                         input logic signed [W-1:0] b,
                                         input logic signed [W-1:0] t);
    logic [3:0] c;
    c = '0;
    if (x < l) c = c | OC_LEFT;
    else if (x > r) c = c | OC_RIGHT;
    if (y < b) c = c | OC_BOTTOM;
    else if (y > t) c = c | OC_TOP;
    return c;
  endfunction

  function automatic logic signed [W:0] diff(input logic signed [W-1:0] p,
                                             input logic signed [W-1:0] q);
    return {p[W-1], p} - {q[W-1], q};
  endfunction

  function automatic logic [W:0] magn(input logic signed [W:0] v);
    return v[W] ? $unsigned(-v) : $unsigned(v);
  endfunction

  lco_state_t                state_r, state_nxt;
  logic signed [W-1:0]       sx_r, sy_r, ex_r, ey_r;
  logic signed [W-1:0]       sx_nxt, sy_nxt, ex_nxt, ey_nxt;
  logic [LCO_STEP_W-1:0]     step_r, step_nxt;
  logic                      ok_r, ok_nxt;
  logic                      side_r, side_nxt;
  logic                      vert_r, vert_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [W-1:0]       sel_r, sel_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_acc_r;
  logic signed [W-1:0]       out_sx_r, out_sy_r, out_ex_r, out_ey_r;
  logic                      out_load;

  logic signed [W-1:0]       bnd_l, bnd_r, bnd_b, bnd_t;
  logic [3:0]                c1, c2, co;
  logic                      vert;
  logic signed [W-1:0]       bnd_sel;
  logic signed [W:0]         da, db, dd;
  logic                      md_start, md_done;
  logic [W:0]                md_q;
  logic signed [W+1:0]       q_s, sum;
  logic signed [W-1:0]       pref, res, ix, iy;

  lco_cfg #(.COORD_WIDTH(W)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .bnd_left   (bnd_l),
    .bnd_right  (bnd_r),
    .bnd_bottom (bnd_b),
    .bnd_top    (bnd_t)
  );

  lco_muldiv #(.COORD_WIDTH(W)) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a_mag (magn(da)),
    .b_mag (magn(db)),
    .d_mag (magn(dd)),
    .done  (md_done),
    .quo   (md_q)
  );

  // edge choice and operand forming for the current step
  always_comb begin
    c1   = outcode(sx_r, sy_r, bnd_l, bnd_r, bnd_b, bnd_t);
    c2   = outcode(ex_r, ey_r, bnd_l, bnd_r, bnd_b, bnd_t);
    co   = (c1 != '0) ? c1 : c2;
    vert = (co & (OC_TOP | OC_BOTTOM)) != '0;
    if (vert) begin
      bnd_sel = ((co & OC_TOP) != '0) ? bnd_t : bnd_b;
      da      = diff(ex_r, sx_r);
      db      = diff(bnd_sel, sy_r);
      dd      = diff(ey_r, sy_r);
    end else begin
      bnd_sel = ((co & OC_RIGHT) != '0) ? bnd_r : bnd_l;
      da      = diff(ey_r, sy_r);
      db      = diff(bnd_sel, sx_r);
      dd      = diff(ex_r, sx_r);
    end
  end

  // intersection from the quotient, start point as reference
  always_comb begin
    q_s  = neg_r ? -$signed({1'b0, md_q}) : $signed({1'b0, md_q});
    pref = vert_r ? sx_r : sy_r;
    sum  = {{2{pref[W-1]}}, pref} + q_s;
    res  = sum[W-1:0];
    ix   = vert_r ? res : sel_r;
    iy   = vert_r ? sel_r : res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    ex_r   <= ex_nxt;
    ey_r   <= ey_nxt;
    ok_r   <= ok_nxt;
    side_r <= side_nxt;
    vert_r <= vert_nxt;
    neg_r  <= neg_nxt;
    sel_r  <= sel_nxt;
    if (out_load) begin
      out_acc_r <= ok_r;
      out_sx_r  <= ok_r ? sx_r : '0;
      out_sy_r  <= ok_r ? sy_r : '0;
      out_ex_r  <= ok_r ? ex_r : '0;
      out_ey_r  <= ok_r ? ey_r : '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    step_nxt      = step_r;
    ok_nxt        = ok_r;
    side_nxt      = side_r;
    vert_nxt      = vert_r;
    neg_nxt       = neg_r;
    sel_nxt       = sel_r;
    md_start      = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_clip.ready;
    in_seg.ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_seg.ready = 1'b1;
        if (in_seg.valid) begin
          sx_nxt    = in_seg.start_x;
          sy_nxt    = in_seg.start_y;
          ex_nxt    = in_seg.end_x;
          ey_nxt    = in_seg.end_y;
          step_nxt  = '0;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if ((c1 | c2) == '0) begin
          ok_nxt    = 1'b1;
          state_nxt = ST_OUT;
        end else if ((c1 & c2) != '0 || step_r == LCO_STEP_W'(LCO_MAX_CLIPS)
                     || dd == '0) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          side_nxt  = c1 != '0;
          vert_nxt  = vert;
          sel_nxt   = bnd_sel;
          neg_nxt   = da[W] ^ db[W] ^ dd[W];
          md_start  = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (md_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (side_r) begin
          sx_nxt = ix;
          sy_nxt = iy;
        end else begin
          ex_nxt = ix;
          ey_nxt = iy;
        end
        step_nxt  = step_r + 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_OUT: begin
        if (!out_valid_r || out_clip.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_clip.valid        = out_valid_r;
  assign out_clip.accepted     = out_acc_r;
  assign out_clip.clip_start_x = out_sx_r;
  assign out_clip.clip_start_y = out_sy_r;
  assign out_clip.clip_end_x   = out_ex_r;
  assign out_clip.clip_end_y   = out_ey_r;

  a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LCO_STEP_W'(LCO_MAX_CLIPS))
    else $error("clip step count beyond limit");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == ST_WAIT)
    else $error("muldiv finished outside wait state");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_acc_r) |->
      (out_sx_r == '0 && out_sy_r == '0 && out_ex_r == '0 && out_ey_r == '0))
    else $error("rejected result carries nonzero coordinates");

  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_seg.valid && in_seg.ready) |=> state_r == ST_DECIDE)
    else $error("accepted request did not start a decision");

endmodule

FILE: rtl/lco_cfg.sv
// Rectangle corner registers and min/max bound forming.
module lco_cfg import lco_pkg::*; #(
  parameter int COORD_WIDTH = LCO_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [LCO_CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  output logic signed [COORD_WIDTH-1:0] bnd_left,
  output logic signed [COORD_WIDTH-1:0] bnd_right,
  output logic signed [COORD_WIDTH-1:0] bnd_bottom,
  output logic signed [COORD_WIDTH-1:0] bnd_top
);

  logic signed [COORD_WIDTH-1:0] x0_r, y0_r, x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r <= '0;
      y0_r <= '0;
      x1_r <= '0;
      y1_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RECT_X0: x0_r <= $signed(cfg_data);
        CFG_RECT_Y0: y0_r <= $signed(cfg_data);
        CFG_RECT_X1: x1_r <= $signed(cfg_data);
        CFG_RECT_Y1: y1_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    bnd_left   = (x0_r < x1_r) ? x0_r : x1_r;
    bnd_right  = (x0_r < x1_r) ? x1_r : x0_r;
    bnd_bottom = (y0_r < y1_r) ? y0_r : y1_r;
    bnd_top    = (y0_r < y1_r) ? y1_r : y0_r;
  end

endmodule

FILE: rtl/lco_muldiv.sv
// Shared multiply then restoring serial divide of magnitudes, one quotient bit a cycle.
module lco_muldiv import lco_pkg::*; #(
  parameter int COORD_WIDTH = LCO_COORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [COORD_WIDTH:0] a_mag,
  input  logic [COORD_WIDTH:0] b_mag,
  input  logic [COORD_WIDTH:0] d_mag,
  output logic                 done,
  output logic [COORD_WIDTH:0] quo
);

  localparam int W     = COORD_WIDTH;
  localparam int CNT_W = $clog2(W + 1);

  lco_md_state_t      state_r, state_nxt;
  logic [W:0]         a_r, b_r, d_r;
  logic [W:0]         rem_r, rem_nxt;
  logic [W:0]         dvd_r, dvd_nxt;
  logic [W:0]         q_r, q_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [2*W+1:0]     prod;
  logic [W+1:0]       rem_sh;
  logic               fits;

  assign prod   = {{(W+1){1'b0}}, a_r} * {{(W+1){1'b0}}, b_r};
  assign rem_sh = {rem_r, dvd_r[W]};
  assign fits   = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == MD_IDLE && start) begin
      a_r <= a_mag;
      b_r <= b_mag;
      d_r <= d_mag;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    q_nxt     = q_r;
    done      = 1'b0;
    unique case (state_r)
      MD_IDLE: begin
        if (start) state_nxt = MD_MUL;
      end
      MD_MUL: begin
        // upper half is already below the divisor, since the quotient fits W+1 bits
        rem_nxt   = prod[2*W+1:W+1];
        dvd_nxt   = prod[W:0];
        cnt_nxt   = '0;
        state_nxt = MD_DIV;
      end
      MD_DIV: begin
        rem_nxt = fits ? (W+1)'(rem_sh - {1'b0, d_r}) : rem_sh[W:0];
        dvd_nxt = {dvd_r[W-1:0], 1'b0};
        q_nxt   = {q_r[W-1:0], fits};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W)) state_nxt = MD_DONE;
      end
      MD_DONE: begin
        done      = 1'b1;
        state_nxt = MD_IDLE;
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  assign quo = q_r;

endmodule
